// ===== hdl/sfm_pkg.sv =====
`timescale 1ns / 1ps

package sfm_pkg;

    localparam int NUM_DEBOUNCE = 5;
    localparam int CNT_W        = 8;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 16;

    // Register indexes on the configuration channel
    localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_LIMIT     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BATTERY_LOW_LEVEL  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GPS_ACCURACY_LIMIT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_COMPASS_MIN_ACC    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_WATER_LOW_LEVEL    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_WATER_MID_LEVEL    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_WATER_HIGH_LEVEL   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_WATER_SAMPLE_DIV   = 3'd7;

    // Register values after reset
    localparam logic [7:0]  RST_DEBOUNCE_LIMIT     = 8'd5;
    localparam logic [6:0]  RST_BATTERY_LOW_LEVEL  = 7'd20;
    localparam logic [15:0] RST_GPS_ACCURACY_LIMIT = 16'd10;
    localparam logic [1:0]  RST_COMPASS_MIN_ACC    = 2'd2;
    localparam logic [11:0] RST_WATER_LOW_LEVEL    = 12'd200;
    localparam logic [11:0] RST_WATER_MID_LEVEL    = 12'd450;
    localparam logic [11:0] RST_WATER_HIGH_LEVEL   = 12'd1500;
    localparam logic [7:0]  RST_WATER_SAMPLE_DIV   = 8'd10;

    // Integrator slots
    localparam int SLOT_GPS_FAIL     = 0;
    localparam int SLOT_COMPASS_FAIL = 1;
    localparam int SLOT_GPS_ACC      = 2;
    localparam int SLOT_COMPASS_ACC  = 3;
    localparam int SLOT_BATTERY_LOW  = 4;

    typedef struct packed {
        logic        gps_valid;
        logic        compass_valid;
        logic [15:0] gps_accuracy;
        logic [1:0]  compass_accuracy;
        logic [6:0]  battery_percent;
        logic        radio_timeout;
        logic        wlan_timeout;
        logic [7:0]  route_points;
        logic        home_known;
        logic [11:0] water_adc;
    } sfm_in_t;

    typedef struct packed {
        logic       gps_fail_flag;
        logic       compass_fail_flag;
        logic       gps_accuracy_flag;
        logic       compass_accuracy_flag;
        logic       battery_low_flag;
        logic       radio_timeout_flag;
        logic       wlan_timeout_flag;
        logic       no_route_flag;
        logic       no_home_flag;
        logic [2:0] water_flags;
        logic [1:0] heading_quality;
    } sfm_out_t;

    typedef struct packed {
        logic [7:0]  debounce_limit;
        logic [6:0]  battery_low_level;
        logic [15:0] gps_accuracy_limit;
        logic [1:0]  compass_min_accuracy;
        logic [11:0] water_low_level;
        logic [11:0] water_mid_level;
        logic [11:0] water_high_level;
        logic [7:0]  water_sample_divider;
    } sfm_cfg_t;

endpackage

// ===== hdl/sfm_if.sv =====
`timescale 1ns / 1ps

interface sfm_tick_if;
    import sfm_pkg::*;
    logic    valid;
    logic    ready;
    sfm_in_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface sfm_result_if;
    import sfm_pkg::*;
    logic     valid;
    logic     ready;
    sfm_out_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface sfm_cfg_if;
    import sfm_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== hdl/sfm_cfg_regs.sv =====
`timescale 1ns / 1ps

module sfm_cfg_regs (
    input  logic             clk,
    input  logic             rst_n,
    sfm_cfg_if.sink          cfg,
    output sfm_pkg::sfm_cfg_t cfg_out
);
    import sfm_pkg::*;

    sfm_cfg_t cfg_reg;

    assign cfg.ready = 1'b1;
    assign cfg_out   = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.debounce_limit       <= RST_DEBOUNCE_LIMIT;
            cfg_reg.battery_low_level    <= RST_BATTERY_LOW_LEVEL;
            cfg_reg.gps_accuracy_limit   <= RST_GPS_ACCURACY_LIMIT;
            cfg_reg.compass_min_accuracy <= RST_COMPASS_MIN_ACC;
            cfg_reg.water_low_level      <= RST_WATER_LOW_LEVEL;
            cfg_reg.water_mid_level      <= RST_WATER_MID_LEVEL;
            cfg_reg.water_high_level     <= RST_WATER_HIGH_LEVEL;
            cfg_reg.water_sample_divider <= RST_WATER_SAMPLE_DIV;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_DEBOUNCE_LIMIT:     cfg_reg.debounce_limit       <= cfg.data[7:0];
                REG_BATTERY_LOW_LEVEL:  cfg_reg.battery_low_level    <= cfg.data[6:0];
                REG_GPS_ACCURACY_LIMIT: cfg_reg.gps_accuracy_limit   <= cfg.data[15:0];
                REG_COMPASS_MIN_ACC:    cfg_reg.compass_min_accuracy <= cfg.data[1:0];
                REG_WATER_LOW_LEVEL:    cfg_reg.water_low_level      <= cfg.data[11:0];
                REG_WATER_MID_LEVEL:    cfg_reg.water_mid_level      <= cfg.data[11:0];
                REG_WATER_HIGH_LEVEL:   cfg_reg.water_high_level     <= cfg.data[11:0];
                REG_WATER_SAMPLE_DIV:   cfg_reg.water_sample_divider <= cfg.data[7:0];
                default:                cfg_reg <= cfg_reg;
            endcase
        end
    end

endmodule

// ===== hdl/sfm_debounce.sv =====
`timescale 1ns / 1ps

module sfm_debounce (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     step,
    input  logic                     cond,
    input  logic [sfm_pkg::CNT_W-1:0] limit,
    output logic                     flag
);
    import sfm_pkg::*;

    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;

    // Count up toward the limit while the condition holds, down toward zero otherwise
    always_comb
    begin
        cnt_next = cnt_reg;
        if (cond)
        begin
            if (cnt_reg < limit)
                cnt_next = cnt_reg + 1'b1;
        end
        else if (cnt_reg != '0)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    assign flag = (cnt_next >= limit);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else if (step)
            cnt_reg <= cnt_next;
    end

endmodule

// ===== hdl/sensor_fault_monitor.sv =====
`timescale 1ns / 1ps

// Sensor fault monitor.
// Each transaction on the tick channel is one monitor tick with sensor and
// status fields; each tick yields exactly one transaction on the result
// channel, in order. The cfg channel writes the eight threshold registers
// by index; it is always ready and should only be used while no tick is
// in flight.
// An accepted tick is registered in the input register, then processed
// into the result register that drives the result channel. Throughput is
// one tick per clock while the receiver takes results: the input and the
// result register form a two-entry pipeline, so the tick channel stays
// ready while a result waits, as long as the input register is empty.
// When the receiver stalls, the result holds; one more tick is buffered in
// the input register and then tick.ready drops until the result is taken.
// Reset (rst_n low, asynchronous) empties the pipeline, clears all five
// debounce counters, the sample phase, the held water reading and the
// sticky water bits, and restores the register defaults.
// Debounced flags rise once a counter reaches debounce_limit; water bits
// stay set until reset.

module sensor_fault_monitor (
    input  logic          clk,
    input  logic          rst_n,
    sfm_tick_if.sink      tick,
    sfm_result_if.source  result,
    sfm_cfg_if.sink       cfg
);
    import sfm_pkg::*;

    sfm_cfg_t cfg_val;

    // Input register
    logic    s1_valid_reg;
    sfm_in_t s1_data_reg;

    // Result register
    logic     out_valid_reg;
    sfm_out_t out_data_reg;
    sfm_out_t out_data_next;

    // Water sampling state
    logic [7:0]  phase_reg;
    logic [7:0]  phase_next;
    logic [8:0]  phase_inc;
    logic [11:0] held_reg;
    logic [11:0] held_next;
    logic [2:0]  sticky_reg;
    logic [2:0]  sticky_next;

    logic                    advance;
    logic                    move;
    logic                    accept;
    logic [NUM_DEBOUNCE-1:0] cond;
    logic [NUM_DEBOUNCE-1:0] flag;

    sfm_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .cfg_out (cfg_val)
    );

    // Result register can take a new value when empty or being drained
    assign advance      = !out_valid_reg || result.ready;
    assign move         = s1_valid_reg && advance;
    assign tick.ready   = !s1_valid_reg || advance;
    assign accept       = tick.valid && tick.ready;
    assign result.valid = out_valid_reg;
    assign result.data  = out_data_reg;

    // Fault conditions that drive the integrators
    always_comb
    begin
        cond[SLOT_GPS_FAIL]     = !s1_data_reg.gps_valid;
        cond[SLOT_COMPASS_FAIL] = !s1_data_reg.compass_valid;
        cond[SLOT_GPS_ACC]      = s1_data_reg.gps_accuracy > cfg_val.gps_accuracy_limit;
        cond[SLOT_COMPASS_ACC]  = s1_data_reg.compass_accuracy < cfg_val.compass_min_accuracy;
        cond[SLOT_BATTERY_LOW]  = s1_data_reg.battery_percent < cfg_val.battery_low_level;
    end

    for (genvar i = 0; i < NUM_DEBOUNCE; i++)
    begin : g_deb
        sfm_debounce u_deb (
            .clk   (clk),
            .rst_n (rst_n),
            .step  (move),
            .cond  (cond[i]),
            .limit (cfg_val.debounce_limit),
            .flag  (flag[i])
        );
    end

    // Latch the water reading on phase zero; wrap the phase at the divider.
    // A divider of zero or one samples on every tick.
    always_comb
    begin
        held_next = (phase_reg == '0) ? s1_data_reg.water_adc : held_reg;
        phase_inc = {1'b0, phase_reg} + 9'd1;
        phase_next = (phase_inc >= {1'b0, cfg_val.water_sample_divider})
                   ? '0 : phase_inc[7:0];
        sticky_next = sticky_reg | {held_next > cfg_val.water_high_level,
                                    held_next > cfg_val.water_mid_level,
                                    held_next > cfg_val.water_low_level};
    end

    always_comb
    begin
        out_data_next.gps_fail_flag         = flag[SLOT_GPS_FAIL];
        out_data_next.compass_fail_flag     = flag[SLOT_COMPASS_FAIL];
        out_data_next.gps_accuracy_flag     = flag[SLOT_GPS_ACC];
        out_data_next.compass_accuracy_flag = flag[SLOT_COMPASS_ACC];
        out_data_next.battery_low_flag      = flag[SLOT_BATTERY_LOW];
        out_data_next.radio_timeout_flag    = s1_data_reg.radio_timeout;
        out_data_next.wlan_timeout_flag     = s1_data_reg.wlan_timeout;
        out_data_next.no_route_flag         = (s1_data_reg.route_points == '0);
        out_data_next.no_home_flag          = !s1_data_reg.home_known;
        out_data_next.water_flags           = sticky_next;
        out_data_next.heading_quality       = s1_data_reg.compass_accuracy;
    end

    // Control and state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            phase_reg     <= '0;
            held_reg      <= '0;
            sticky_reg    <= '0;
        end
        else
        begin
            if (accept)
                s1_valid_reg <= 1'b1;
            else if (advance)
                s1_valid_reg <= 1'b0;

            if (move)
                out_valid_reg <= 1'b1;
            else if (result.ready)
                out_valid_reg <= 1'b0;

            if (move)
            begin
                phase_reg  <= phase_next;
                held_reg   <= held_next;
                sticky_reg <= sticky_next;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
            s1_data_reg <= tick.data;
        if (move)
            out_data_reg <= out_data_next;
    end

endmodule

// ===== hdl/sfm_checker.sv =====
`timescale 1ns / 1ps

module sfm_checker (
    input logic                  clk,
    input logic                  rst_n,
    input logic                  tick_valid,
    input logic                  tick_ready,
    input logic                  result_valid,
    input logic                  result_ready,
    input sfm_pkg::sfm_out_t     result_data
);
    import sfm_pkg::*;

    logic       tick_acc;
    logic       res_acc;
    logic [1:0] pending_reg;
    logic [2:0] water_seen_reg;

    assign tick_acc = tick_valid && tick_ready;
    assign res_acc  = result_valid && result_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg    <= '0;
            water_seen_reg <= '0;
        end
        else
        begin
            pending_reg <= pending_reg + {1'b0, tick_acc} - {1'b0, res_acc};
            if (res_acc)
                water_seen_reg <= result_data.water_flags;
        end
    end

    // Hold a stalled result
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result_data))
        else $error("stalled result changed");

    // Never present a result for a tick that was not taken
    a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> pending_reg != 2'd0)
        else $error("result without a pending tick");

    // Two ticks at most in flight
    a_depth: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg != 2'd3)
        else $error("more ticks in flight than pipeline entries");

    // Keep taking ticks while the result side drains
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !result_valid || result_ready |-> tick_ready)
        else $error("tick channel blocked with result side free");

    // Water bits never clear between results
    a_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result_data.water_flags & water_seen_reg) == water_seen_reg)
        else $error("sticky water bit cleared");

endmodule

bind sensor_fault_monitor sfm_checker u_sfm_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .tick_valid   (tick.valid),
    .tick_ready   (tick.ready),
    .result_valid (result.valid),
    .result_ready (result.ready),
    .result_data  (result.data)
);
